// File: rtl/sky_sun_color_from_elevation_core_assert.svh
// assertion macros for the sun and sky color block
`ifndef SKY_SUN_COLOR_FROM_ELEVATION_CORE_ASSERT_SVH
`define SKY_SUN_COLOR_FROM_ELEVATION_CORE_ASSERT_SVH
`ifndef ASSERT_OFF
`define SSCFE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define SSCFE_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SSCFE_ASSERT(lbl, prop, msg)
`define SSCFE_ASSERT_RST(lbl, prop, msg)
`endif
`endif

// File: rtl/sscfe_pkg.sv
// shared types, constants and color tables for the sun and sky color block
`timescale 1ns / 1ps
package sscfe_pkg;

  localparam int ELEV_W  = 15;
  localparam int OUT_W   = 16;
  localparam int XYZ_W   = 18;
  localparam int H_W     = 21;
  localparam int OFF_W   = 22;
  localparam int MA_W    = 23;
  localparam int MB_W    = 19;
  localparam int PROD_W  = MA_W + MB_W;
  localparam int C_W     = 39;
  localparam int DEF_COLOR_FRAC_BITS = 15;

  localparam logic signed [MA_W-1:0] HOUR_GAIN  = 23'sd4005265;
  localparam logic [37:0]            HOUR_BIAS  = 38'h18_0001_0000;
  localparam logic signed [C_W-1:0]  BLUE_FLOOR = 39'sd107374;
  localparam logic [OUT_W-1:0]       OUT_MAX    = 16'hFFFF;

  typedef logic signed [MB_W-1:0] coef_t;

  localparam coef_t MAT [3][3] = '{
    '{ 19'sd212368, -19'sd100739, -19'sd32672},
    '{-19'sd63521,   19'sd122945,  19'sd2723},
    '{ 19'sd3647,   -19'sd13372,   19'sd69292}
  };

  localparam int SKY_MICRO [24][3] = '{
    '{308000, 308000, 411000}, '{308000, 308000, 410000},
    '{301000, 301000, 402000}, '{287000, 287000, 382000},
    '{258000, 258000, 344000}, '{258000, 258000, 344000},
    '{0, 0, 0},
    '{962851, 1000000, 1747835}, '{967787, 1000000, 1776762},
    '{970173, 1000000, 1788413}, '{971431, 1000000, 1794102},
    '{972099, 1000000, 1797096}, '{972385, 1000000, 1798389},
    '{972361, 1000000, 1798278}, '{972020, 1000000, 1796740},
    '{971275, 1000000, 1793407}, '{969885, 1000000, 1787078},
    '{967216, 1000000, 1773758}, '{961668, 1000000, 1739891},
    '{0, 0, 0},
    '{264000, 264000, 352000}, '{264000, 264000, 352000},
    '{290000, 290000, 386000}, '{303000, 303000, 404000}
  };

  localparam int SUN_MICRO [24][3] = '{
    '{0, 0, 0}, '{0, 0, 0}, '{0, 0, 0}, '{0, 0, 0}, '{0, 0, 0}, '{0, 0, 0},
    '{0, 0, 0},
    '{12703322, 12989393, 9100411},  '{13202644, 13597814, 11524929},
    '{13192974, 13597458, 12264488}, '{13132943, 13535914, 12560032},
    '{13088722, 13489535, 12692996}, '{13067827, 13467483, 12745179},
    '{13069653, 13469413, 12740822}, '{13094319, 13495428, 12678066},
    '{13142133, 13545483, 12526785}, '{13201734, 13606017, 12188001},
    '{13182774, 13572725, 11311157}, '{12448635, 12672520, 8267771},
    '{0, 0, 0}, '{0, 0, 0}, '{0, 0, 0}, '{0, 0, 0}, '{0, 0, 0}
  };

  typedef struct packed {
    logic [4:0]                 t0;
    logic                       wide;
    logic [2:0][XYZ_W-1:0]      v0;
    logic [2:0][XYZ_W-1:0]      v1;
  } seg_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_HOUR_MUL, ST_HOUR_ACC, ST_INT_MUL, ST_INT_ACC, ST_MAT_MUL,
    ST_MAT_ACC, ST_PEAK, ST_DIV_GO, ST_DIV_WAIT, ST_DONE
  } state_t;

  function automatic logic [XYZ_W-1:0] q14(input int micro);
    longint p;
    p = (longint'(micro) * 16384 + 500000) / 1000000;
    return p[XYZ_W-1:0];
  endfunction

  // segment of the hour table that covers [u, u+1)
  function automatic seg_t seg_lookup(input logic sun, input logic [4:0] u);
    seg_t       s;
    logic [4:0] a;
    logic [4:0] b;
    if (!sun && u >= 5'd23) begin
      a = 5'd23; b = 5'd23;
    end else if (sun && u < 5'd5) begin
      a = 5'd5; b = 5'd5;
    end else if (sun && u >= 5'd20) begin
      a = 5'd20; b = 5'd20;
    end else if (u == 5'd5 || u == 5'd6) begin
      a = 5'd5; b = 5'd7;
    end else if (u == 5'd18 || u == 5'd19) begin
      a = 5'd18; b = 5'd20;
    end else begin
      a = u; b = u + 5'd1;
    end
    s.t0   = a;
    s.wide = (b - a) == 5'd2;
    for (int k = 0; k < 3; k++) begin
      s.v0[k] = '0;
      s.v1[k] = '0;
      for (int i = 0; i < 24; i++) begin
        if (a == 5'(i)) s.v0[k] = sun ? q14(SUN_MICRO[i][k]) : q14(SKY_MICRO[i][k]);
        if (b == 5'(i)) s.v1[k] = sun ? q14(SUN_MICRO[i][k]) : q14(SKY_MICRO[i][k]);
      end
    end
    return s;
  endfunction

endpackage

// File: rtl/sscfe_div.sv
// restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
module sscfe_div import sscfe_pkg::*; #(
  parameter int NW = 54,
  parameter int DW = 38,
  parameter int QW = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          done,
  output logic [QW-1:0] quo
);

  localparam int CNT_W = $clog2(QW);

  logic [NW-1:0]    rem;
  logic [NW-1:0]    dsh;
  logic [CNT_W-1:0] cnt;
  logic             busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(QW - 1);
        rem  <= num;
        dsh  <= NW'(den) << (QW - 1);
        quo  <= '0;
      end else if (busy) begin
        if (rem >= dsh) begin
          rem <= rem - dsh;
          quo <= {quo[QW-2:0], 1'b1};
        end else begin
          quo <= {quo[QW-2:0], 1'b0};
        end
        dsh <= dsh >> 1;
        cnt <= cnt - CNT_W'(1);
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// File: rtl/sky_sun_color_from_elevation_core.sv
// sun and sky color from sun elevation, sequenced over one shared multiplier
//   channel   | direction | handshake                 | beat
//   elevation | in        | elev_valid / elev_ready   | elevation
//   color     | out       | color_valid / color_ready | sky xyz, sky rgb, sun rgb
// one beat runs from accept to next accept through 25 multiply-accumulate steps on the
// shared multiplier, six peak search steps, six restoring divisions, the output state
// and the idle state. elev_ready is high only while idle; a finished beat waits in
// the output register while the next elevation is taken, and the sequencer holds in
// its last state while that register is still full.
// rst is synchronous and clears the sequencer and the output valid.
`timescale 1ns / 1ps
`include "sky_sun_color_from_elevation_core_assert.svh"
module sky_sun_color_from_elevation_core import sscfe_pkg::*; #(
  parameter int COLOR_FRAC_BITS = DEF_COLOR_FRAC_BITS
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     elev_valid,
  output logic                     elev_ready,
  input  logic signed [ELEV_W-1:0] elevation,
  output logic                     color_valid,
  input  logic                     color_ready,
  output logic [OUT_W-1:0]         sky_x,
  output logic [OUT_W-1:0]         sky_y,
  output logic [OUT_W-1:0]         sky_z,
  output logic [OUT_W-1:0]         sky_red,
  output logic [OUT_W-1:0]         sky_green,
  output logic [OUT_W-1:0]         sky_blue,
  output logic [OUT_W-1:0]         sun_red,
  output logic [OUT_W-1:0]         sun_green,
  output logic [OUT_W-1:0]         sun_blue
);

  localparam int QW = COLOR_FRAC_BITS + 1;
  localparam int DW = C_W - 1;
  localparam int NW = C_W + COLOR_FRAC_BITS;

  state_t state, state_next;

  logic signed [ELEV_W-1:0] elev;
  logic [H_W-1:0]           h;
  logic signed [PROD_W-1:0] prod;
  logic signed [MA_W-1:0]   mul_a;
  logic signed [MB_W-1:0]   mul_b;
  logic                     sel_sun;
  logic [1:0]               k;
  logic [1:0]               j;
  logic [XYZ_W-1:0]         xyz [2][3];
  logic signed [C_W-1:0]    acc;
  logic signed [C_W-1:0]    c [2][3];
  logic [DW-1:0]            m;
  logic [OUT_W-1:0]         res [2][3];

  seg_t                     seg;
  logic signed [OFF_W-1:0]  off;
  logic signed [MB_W-1:0]   dv;
  logic signed [PROD_W-1:0] hsum;
  logic                     neg;
  logic [PROD_W-1:0]        mag;
  logic [PROD_W-1:0]        rnd;
  logic signed [19:0]       ival;
  logic signed [C_W-1:0]    acc_sum;
  logic signed [C_W-1:0]    cand;
  logic signed [C_W-1:0]    base;
  logic signed [C_W-1:0]    cur;
  logic [DW-1:0]            vpos;
  logic                     div_start;
  logic [NW-1:0]            div_num;
  logic                     div_done;
  logic [QW-1:0]            div_q;
  logic [QW+OUT_W-1:0]      qx;
  logic [OUT_W-1:0]         qsat;

  function automatic logic [OUT_W-1:0] sat_xyz(input logic [XYZ_W-1:0] v);
    return (v > XYZ_W'(OUT_MAX)) ? OUT_MAX : v[OUT_W-1:0];
  endfunction

  assign seg  = seg_lookup(sel_sun, h[H_W-1 -: 5]);
  assign off  = $signed({1'b0, h}) - $signed({1'b0, seg.t0, 16'b0});
  assign dv   = $signed({1'b0, seg.v1[k]}) - $signed({1'b0, seg.v0[k]});
  assign hsum = $signed({4'b0, HOUR_BIAS}) + prod;
  assign neg  = prod < 0;
  assign mag  = neg ? PROD_W'(-prod) : PROD_W'(prod);
  assign rnd  = seg.wide ? (mag + (PROD_W'(1) << 16)) >> 17
                         : (mag + (PROD_W'(1) << 15)) >> 16;
  assign ival = $signed({2'b0, seg.v0[k]}) +
                (neg ? -$signed(rnd[19:0]) : $signed(rnd[19:0]));
  assign acc_sum = acc + prod[C_W-1:0];

  assign cand = (k == 2'd0) ? c[sel_sun][2] : (k == 2'd1) ? c[sel_sun][0] : c[sel_sun][1];
  assign base = (k == 2'd0) ? BLUE_FLOOR : $signed({1'b0, m});

  assign cur     = c[sel_sun][k];
  assign vpos    = (cur > 0) ? cur[DW-1:0] : '0;
  assign div_num = (NW'(vpos) << COLOR_FRAC_BITS) + NW'(m >> 1);

  assign qx   = (QW + OUT_W)'(div_q);
  assign qsat = (qx > (QW + OUT_W)'(OUT_MAX)) ? OUT_MAX : qx[OUT_W-1:0];

  sscfe_div #(.NW(NW), .DW(DW), .QW(QW)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (m),
    .done  (div_done),
    .quo   (div_q)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:     if (elev_valid) state_next = ST_HOUR_MUL;
      ST_HOUR_MUL: state_next = ST_HOUR_ACC;
      ST_HOUR_ACC: state_next = ST_INT_MUL;
      ST_INT_MUL:  state_next = ST_INT_ACC;
      ST_INT_ACC:  state_next = (k == 2'd2 && sel_sun) ? ST_MAT_MUL : ST_INT_MUL;
      ST_MAT_MUL:  state_next = ST_MAT_ACC;
      ST_MAT_ACC:  state_next = (j == 2'd2 && k == 2'd2 && sel_sun) ? ST_PEAK : ST_MAT_MUL;
      ST_PEAK:     if (k == 2'd2) state_next = ST_DIV_GO;
      ST_DIV_GO:   state_next = ST_DIV_WAIT;
      ST_DIV_WAIT: begin
        if (div_done) begin
          if (k != 2'd2)    state_next = ST_DIV_GO;
          else if (sel_sun) state_next = ST_DONE;
          else              state_next = ST_PEAK;
        end
      end
      ST_DONE:     if (!color_valid || color_ready) state_next = ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    elev_ready = 1'b0;
    div_start  = 1'b0;
    mul_a      = '0;
    mul_b      = '0;
    unique case (state)
      ST_IDLE:     elev_ready = 1'b1;
      ST_HOUR_MUL: begin
        mul_a = HOUR_GAIN;
        mul_b = MB_W'(elev);
      end
      ST_INT_MUL:  begin
        mul_a = MA_W'(off);
        mul_b = dv;
      end
      ST_MAT_MUL:  begin
        mul_a = MA_W'(MAT[k][j]);
        mul_b = $signed({1'b0, xyz[sel_sun][j]});
      end
      ST_DIV_GO:   div_start = 1'b1;
      default:     ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      color_valid <= 1'b0;
      sel_sun     <= 1'b0;
      k           <= '0;
      j           <= '0;
    end else begin
      state <= state_next;
      prod  <= mul_a * mul_b;
      if (color_valid && color_ready && state != ST_DONE) color_valid <= 1'b0;
      case (state)
        ST_IDLE: begin
          elev    <= elevation;
          sel_sun <= 1'b0;
          k       <= '0;
          j       <= '0;
        end
        ST_HOUR_ACC: h <= hsum[37:17];
        ST_INT_ACC: begin
          xyz[sel_sun][k] <= ival[XYZ_W-1:0];
          acc <= '0;
          if (k == 2'd2) begin
            k       <= '0;
            sel_sun <= ~sel_sun;
          end else begin
            k <= k + 2'd1;
          end
        end
        ST_MAT_ACC: begin
          if (j == 2'd2) begin
            c[sel_sun][k] <= acc_sum;
            acc <= '0;
            j   <= '0;
            if (k == 2'd2) begin
              k       <= '0;
              sel_sun <= ~sel_sun;
            end else begin
              k <= k + 2'd1;
            end
          end else begin
            acc <= acc_sum;
            j   <= j + 2'd1;
          end
        end
        ST_PEAK: begin
          m <= (cand > base) ? cand[DW-1:0] : base[DW-1:0];
          k <= (k == 2'd2) ? 2'd0 : k + 2'd1;
        end
        ST_DIV_WAIT: begin
          if (div_done) begin
            res[sel_sun][k] <= qsat;
            if (k == 2'd2) begin
              k <= '0;
              if (!sel_sun) sel_sun <= 1'b1;
            end else begin
              k <= k + 2'd1;
            end
          end
        end
        ST_DONE: begin
          if (!color_valid || color_ready) begin
            color_valid <= 1'b1;
            sky_x     <= sat_xyz(xyz[0][0]);
            sky_y     <= sat_xyz(xyz[0][1]);
            sky_z     <= sat_xyz(xyz[0][2]);
            sky_red   <= res[0][0];
            sky_green <= res[0][1];
            sky_blue  <= res[0][2];
            sun_red   <= res[1][0];
            sun_green <= res[1][1];
            sun_blue  <= res[1][2];
          end
        end
        default: ;
      endcase
    end
  end

  `SSCFE_ASSERT(a_take_leaves_idle, elev_valid && elev_ready |=> !elev_ready, "beat taken but still idle")
  `SSCFE_ASSERT(a_div_done_in_wait, div_done |-> state == ST_DIV_WAIT, "divider done outside wait")
  `SSCFE_ASSERT(a_quo_bound, div_done |-> div_q <= (QW'(1) << COLOR_FRAC_BITS), "quotient above one")
  `SSCFE_ASSERT_RST(a_reset_clear, rst |=> !color_valid && state == ST_IDLE, "reset left work")

endmodule
